FILE: hdl/coord_frame_parser_assert.svh
// assertion macros for the coordinate frame parser
// each check runs on clk_i and is switched off while rst_ni is low
`ifndef COORD_FRAME_PARSER_ASSERT_SVH
`define COORD_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// check a property after the reset has been released
`define CFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("coord_frame_parser check failed");

// check that a condition holds in the cycle after a trigger
`define CFP_ASSERT_NEXT(lbl, trig, cond) \
  `CFP_ASSERT(lbl, (trig) |=> (cond))

`else

`define CFP_ASSERT(lbl, prop)
`define CFP_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

FILE: hdl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  // frame markers
  localparam logic [7:0] HDR_FIRST  = 8'hA3;
  localparam logic [7:0] HDR_SECOND = 8'hB3;
  localparam logic [7:0] TRAILER    = 8'hC3;

  // frame layout
  localparam int unsigned PAYLOAD_LEN = 16;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);
  localparam int unsigned POS_W       = 5;

  localparam logic [POS_W-1:0] POS_HDR_FIRST  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR_SECOND = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PAYLOAD    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_TRAILER    = POS_W'(18);

  typedef logic [15:0] coord_t;

  // first member sits in the highest bits, so point0_x lands lowest
  typedef struct packed {
    coord_t point3_y;
    coord_t point3_x;
    coord_t point2_y;
    coord_t point2_x;
    coord_t point1_y;
    coord_t point1_x;
    coord_t point0_y;
    coord_t point0_x;
  } points_t;

  // status of the frame tracker towards the top level
  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] pos;
  } track_status_t;

endpackage

`default_nettype wire

FILE: hdl/coord_frame_parser.sv
// channel    dir  bits  content
// s_axis     in   8     rx_byte, one received serial byte
// m_axis     out  128   four points, point0_x lowest up to point3_y
//
// one item a cycle unless a trailer waits on a stalled output: a byte goes
// into the input register, is parsed there against the frame position and
// a good trailer loads the result register. a byte with no result never
// waits for the output side. reset clears the frame position and both valid
// flags; payload bytes are only read after a full frame has rewritten them.
// a stalled output holds a trailer byte in the input register until free.
`default_nettype none

module coord_frame_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // point0_x, point0_y, point1_x,
                                            // point1_y, point2_x, point2_y,
                                            // point3_x, point3_y (16 b each)
);

  logic                   in_vld_q, in_vld_d;
  logic [7:0]             in_byte_q;
  logic                   in_take;
  logic                   advance;
  logic                   out_free;
  logic                   load;
  cfp_pkg::track_status_t status;
  cfp_pkg::points_t       points;
  cfp_pkg::points_t       out_points;

  // held item moves on unless it needs a busy result register
  assign advance       = in_vld_q && (!status.emit || out_free);
  assign load          = advance && status.emit;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // frame position and payload
  cfp_frame_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (in_vld_q),
    .byte_i   (in_byte_q),
    .take_i   (advance),
    .status_o (status),
    .points_o (points)
  );

  // result register
  cfp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .points_i (points),
    .tready_i (m_axis_tready),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid),
    .points_o (out_points)
  );

  assign m_axis_tdata = out_points;

  // checks
`include "coord_frame_parser_assert.svh"

  `CFP_ASSERT(a_pos_range, status.pos <= cfp_pkg::POS_TRAILER)
  `CFP_ASSERT_NEXT(a_hold_blocked, in_vld_q && !advance, in_vld_q && $stable(in_byte_q))
  `CFP_ASSERT(a_result_from_trailer, $rose(m_axis_tvalid) |-> $past(load))

endmodule

`default_nettype wire

FILE: hdl/cfp_frame_track.sv
`default_nettype none

module cfp_frame_track (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   vld_i,
  input  wire logic [7:0]             byte_i,
  input  wire logic                   take_i,
  output cfp_pkg::track_status_t      status_o,
  output cfp_pkg::points_t            points_o
);

  logic [cfp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                payload_q [cfp_pkg::PAYLOAD_LEN];
  logic                      wr_payload;
  logic [cfp_pkg::POS_W-1:0] pos_rel;
  logic [cfp_pkg::IDX_W-1:0] wr_idx;
  logic                      at_trailer;

  assign pos_rel    = pos_q - cfp_pkg::POS_PAYLOAD;
  assign wr_idx     = pos_rel[cfp_pkg::IDX_W-1:0];
  assign at_trailer = (pos_q >= cfp_pkg::POS_TRAILER);

  // next frame position and payload write enable
  always_comb begin
    pos_d      = pos_q;
    wr_payload = 1'b0;
    priority if (pos_q == cfp_pkg::POS_HDR_FIRST) begin
      pos_d = (byte_i == cfp_pkg::HDR_FIRST) ? cfp_pkg::POS_HDR_SECOND
                                             : cfp_pkg::POS_HDR_FIRST;
    end else if (pos_q == cfp_pkg::POS_HDR_SECOND) begin
      // a wrong second header is dropped, not tried as a first header
      pos_d = (byte_i == cfp_pkg::HDR_SECOND) ? cfp_pkg::POS_PAYLOAD
                                              : cfp_pkg::POS_HDR_FIRST;
    end else if (!at_trailer) begin
      pos_d      = pos_q + cfp_pkg::POS_W'(1);
      wr_payload = 1'b1;
    end else begin
      pos_d = cfp_pkg::POS_HDR_FIRST;
    end
  end

  // frame position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= cfp_pkg::POS_HDR_FIRST;
    end else if (take_i) begin
      pos_q <= pos_d;
    end
  end

  // payload bytes, undefined until written
  always_ff @(posedge clk_i) begin
    if (take_i && wr_payload) begin
      payload_q[wr_idx] <= byte_i;
    end
  end

  // good trailer on the item now held
  assign status_o.emit = vld_i && at_trailer && (byte_i == cfp_pkg::TRAILER);
  assign status_o.pos  = pos_q;

  // little-endian coordinate pairs
  assign points_o.point0_x = {payload_q[1],  payload_q[0]};
  assign points_o.point0_y = {payload_q[3],  payload_q[2]};
  assign points_o.point1_x = {payload_q[5],  payload_q[4]};
  assign points_o.point1_y = {payload_q[7],  payload_q[6]};
  assign points_o.point2_x = {payload_q[9],  payload_q[8]};
  assign points_o.point2_y = {payload_q[11], payload_q[10]};
  assign points_o.point3_x = {payload_q[13], payload_q[12]};
  assign points_o.point3_y = {payload_q[15], payload_q[14]};

endmodule

`default_nettype wire

FILE: hdl/cfp_out_stage.sv
`default_nettype none

module cfp_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire cfp_pkg::points_t points_i,
  input  wire logic             tready_i,
  output logic                  free_o,
  output logic                  tvalid_o,
  output cfp_pkg::points_t      points_o
);

  logic             vld_q, vld_d;
  cfp_pkg::points_t data_q;

  // register is free when empty or being drained this cycle
  assign free_o = !vld_q || tready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (tready_i) begin
      vld_d = 1'b0;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= points_i;
    end
  end

  assign tvalid_o = vld_q;
  assign points_o = data_q;

endmodule

`default_nettype wire
